### src/fns_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and match functions for the file name sanitizer.
// No dependencies; used by every module under src.
package fns_pkg;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [2:0] POS_SAT = 3'd5;

   localparam logic [7:0] CH_UNDERSCORE = "_";
   localparam logic [7:0] CH_DOT        = ".";
   localparam logic [7:0] CH_SPACE      = " ";
   localparam logic [7:0] CH_CTRL_MAX   = 8'd31;
   localparam logic [7:0] CH_DIGIT_LO   = 8'h31;
   localparam logic [7:0] CH_DIGIT_HI   = 8'h39;

   localparam logic [23:0] DEV_CON = "CON";
   localparam logic [23:0] DEV_PRN = "PRN";
   localparam logic [23:0] DEV_AUX = "AUX";
   localparam logic [23:0] DEV_NUL = "NUL";
   localparam logic [23:0] DEV_COM = "COM";
   localparam logic [23:0] DEV_LPT = "LPT";

   // one queue entry: up to three bytes in emission order
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            last;
      logic [1:0]      status;
   } fns_entry_type;

   typedef struct packed {
      logic          valid;
      fns_entry_type entry;
   } fns_push_type;

   function automatic logic [7:0] upper_ascii(input logic [7:0] b);
      if (b >= "a" && b <= "z") begin
         return b - 8'd32;
      end
      return b;
   endfunction

   function automatic logic must_replace(input logic [7:0] b);
      return (b >= 8'd1 && b <= CH_CTRL_MAX) || b == "\\" || b == "/" || b == ":" ||
             b == "*" || b == "?" || b == "\"" || b == "<" || b == ">" || b == "|";
   endfunction

   function automatic logic is_three_dev(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
      logic [23:0] w;
      w = {upper_ascii(a), upper_ascii(b), upper_ascii(c)};
      return w == DEV_CON || w == DEV_PRN || w == DEV_AUX || w == DEV_NUL;
   endfunction

   function automatic logic is_numbered_dev(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c, input logic [7:0] d);
      logic [23:0] w;
      w = {upper_ascii(a), upper_ascii(b), upper_ascii(c)};
      return d >= CH_DIGIT_LO && d <= CH_DIGIT_HI && (w == DEV_COM || w == DEV_LPT);
   endfunction

endpackage

### src/fns_front.sv
`timescale 1ns / 1ps
// Front end: takes input beats, cleans bytes, tracks name position and status,
// and packs the bytes each beat releases into one queue entry. Uses fns_pkg.
module fns_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_in_last,
   input  logic                  fifo_full,
   output fns_pkg::fns_push_type push
);

   logic [2:0] pos_ff, pos_in;
   logic [1:0] flags_ff, flags_in;
   logic [7:0] head_ff [4];

   logic       accept;
   logic       rep;
   logic [7:0] c;
   logic [7:0] c_out;
   logic [7:0] h0_out;
   logic       rep_any;
   logic       warn;
   logic [1:0] st;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      rep     = fns_pkg::must_replace(req_in_byte);
      c       = rep ? fns_pkg::CH_UNDERSCORE : req_in_byte;
      c_out   = c;
      h0_out  = head_ff[0];
      rep_any = rep;
      warn    = 1'b0;
      if (pos_ff == 3'd0 && c == fns_pkg::CH_SPACE) begin
         warn = 1'b1;
      end
      if (pos_ff == 3'd3 && c == fns_pkg::CH_DOT &&
          fns_pkg::is_three_dev(head_ff[0], head_ff[1], head_ff[2])) begin
         warn = 1'b1;
      end
      if (pos_ff == 3'd4 && c == fns_pkg::CH_DOT &&
          fns_pkg::is_numbered_dev(head_ff[0], head_ff[1], head_ff[2], head_ff[3])) begin
         warn = 1'b1;
      end
      if (req_in_last) begin
         if (pos_ff == 3'd2 && fns_pkg::is_three_dev(head_ff[0], head_ff[1], c)) begin
            warn = 1'b1;
         end
         if (pos_ff == 3'd3 &&
             fns_pkg::is_numbered_dev(head_ff[0], head_ff[1], head_ff[2], c)) begin
            warn = 1'b1;
         end
         // a name of just "." or ".."
         if (pos_ff == 3'd0 && c == fns_pkg::CH_DOT) begin
            c_out   = fns_pkg::CH_UNDERSCORE;
            rep_any = 1'b1;
         end
         if (pos_ff == 3'd1 && head_ff[0] == fns_pkg::CH_DOT && c == fns_pkg::CH_DOT) begin
            h0_out  = fns_pkg::CH_UNDERSCORE;
            c_out   = fns_pkg::CH_UNDERSCORE;
            rep_any = 1'b1;
         end
         if (pos_ff != 3'd0 && (c_out == fns_pkg::CH_DOT || c_out == fns_pkg::CH_SPACE)) begin
            warn = 1'b1;
         end
      end
      st = flags_ff | {warn, rep_any};

      push.entry.bytes  = {fns_pkg::CH_UNDERSCORE, fns_pkg::CH_UNDERSCORE, c_out};
      push.entry.count  = 2'd1;
      push.entry.last   = req_in_last;
      push.entry.status = req_in_last ? st : 2'd0;
      push.valid        = 1'b0;
      case (pos_ff)
         3'd0: begin
            push.valid = accept && req_in_last;
         end
         3'd1: begin
            push.entry.bytes[0] = h0_out;
            push.entry.bytes[1] = c_out;
            push.entry.count    = 2'd2;
            push.valid          = accept && req_in_last;
         end
         3'd2: begin
            push.entry.bytes[0] = head_ff[0];
            push.entry.bytes[1] = head_ff[1];
            push.entry.bytes[2] = c_out;
            push.entry.count    = 2'd3;
            push.valid          = accept;
         end
         default: begin
            push.valid = accept;
         end
      endcase

      if (req_in_last) begin
         pos_in   = 3'd0;
         flags_in = 2'd0;
      end else begin
         pos_in   = (pos_ff < fns_pkg::POS_SAT) ? pos_ff + 3'd1 : fns_pkg::POS_SAT;
         flags_in = st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 3'd0;
         flags_ff <= 2'd0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pos_ff < 3'd4) begin
         head_ff[pos_ff[1:0]] <= c;
      end
   end

endmodule

### src/fns_fifo.sv
`timescale 1ns / 1ps
// Short queue of byte-group entries between front and back end.
// Uses fns_pkg for the entry type and depth.
module fns_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  fns_pkg::fns_push_type  push,
   input  logic                   pop,
   output logic                   full,
   output logic                   not_empty,
   output fns_pkg::fns_entry_type head
);

   fns_pkg::fns_entry_type mem_ff [fns_pkg::FIFO_DEPTH];
   logic [fns_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [fns_pkg::FIFO_CNT_W-1:0] cnt_ff;

   assign full      = cnt_ff == fns_pkg::FIFO_CNT_W'(fns_pkg::FIFO_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push.valid && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push.valid) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

### src/fns_back.sv
`timescale 1ns / 1ps
// Back end: walks the head queue entry one byte per result beat.
// Uses fns_pkg for the entry type.
module fns_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   not_empty,
   input  fns_pkg::fns_entry_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_out_last,
   output logic [1:0]             rsp_status
);

   logic [1:0] idx_ff, idx_in;
   logic       final_byte;

   always_comb begin
      final_byte   = idx_ff == head.count - 2'd1;
      rsp_valid    = not_empty;
      rsp_out_byte = head.bytes[idx_ff];
      rsp_out_last = head.last && final_byte;
      rsp_status   = final_byte ? head.status : 2'd0;
      pop          = rsp_valid && !rsp_stall && final_byte;
      idx_in       = idx_ff;
      if (rsp_valid && !rsp_stall) begin
         idx_in = final_byte ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

### src/file_name_sanitizer.sv
`timescale 1ns / 1ps
// File name sanitizer: streams a file name in and its cleaned bytes out.
// Depends on fns_pkg, fns_front, fns_fifo and fns_back.
//
// Usage:
//   req channel: one name byte per beat (req_in_byte), req_in_last on the final
//   byte. rsp channel: one cleaned byte per beat, rsp_out_last on the final
//   byte, rsp_status on that beat (bit0 replaced, bit1 warning), else zero.
//   Both channels: beat moves when valid is high and stall is low.
// Holding: the first two bytes of a name are held until the third byte or the
//   end of the name arrives; the bytes that a taken byte releases are written
//   into the queue and reach rsp from its head.
// Throughput: one byte per cycle in and out unless stalled. The third byte of
//   a name drops a three-byte entry into the 4-deep queue, drained by the back
//   end one byte per cycle; the queue absorbs that burst, and req_stall rises
//   only when the queue is full (back end stalled by rsp_stall).
// Reset: synchronous, empties the queue and starts a new name.
module file_name_sanitizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic [1:0] rsp_status
);

   fns_pkg::fns_push_type  push;
   fns_pkg::fns_entry_type head;
   logic                   fifo_full;
   logic                   not_empty;
   logic                   pop;

   fns_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .fifo_full   (fifo_full),
      .push        (push)
   );

   fns_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .full      (fifo_full),
      .not_empty (not_empty),
      .head      (head)
   );

   fns_back u_back (
      .clock        (clock),
      .reset        (reset),
      .not_empty    (not_empty),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_status   (rsp_status)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !fifo_full)
      else $error("queue push while full");

   a_last_pushes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_in_last) |-> push.valid)
      else $error("final byte released no output");

   a_status_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_last) |-> rsp_status == 2'd0)
      else $error("status on a non-final beat");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

### tb/sanitized_name_checker.sv
`timescale 1ns / 1ps
// Checker for the file name sanitizer: predicts the cleaned bytes and status of
// every req beat and compares them with the rsp beats. Depends on fns_pkg.
module sanitized_name_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_out_last,
   input  logic [1:0] rsp_status,
   output int         mismatches,
   output int         pending
);

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic [1:0] status;
   } clean_beat_type;

   clean_beat_type expected_beats[$];
   logic [2:0]     name_pos;
   logic [7:0]     head [4];
   logic [1:0]     name_flags;
   int             fail_count = 0;

   assign mismatches = fail_count;

   function automatic logic is_illegal_char(input logic [7:0] b);
      case (b)
         "\\", "/", ":", "*", "?", "\"", "<", ">", "|": return 1'b1;
         default: return b != 8'd0 && b <= fns_pkg::CH_CTRL_MAX;
      endcase
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] b);
      return (b >= "a" && b <= "z") ? (b ^ 8'h20) : b;
   endfunction

   function automatic logic [23:0] head_word();
      return {fold_case(head[0]), fold_case(head[1]), fold_case(head[2])};
   endfunction

   task automatic expect_beat(input logic [7:0] ch, input logic last);
      clean_beat_type e;
      e.ch     = ch;
      e.last   = last;
      e.status = last ? name_flags : 2'd0;
      expected_beats.push_back(e);
   endtask

   task automatic predict_clean_bytes(input logic [7:0] raw, input logic last);
      logic [7:0] c;
      logic [2:0] p;
      logic       three_dev;
      logic       num_dev;
      c = raw;
      p = (name_pos > fns_pkg::POS_SAT) ? fns_pkg::POS_SAT : name_pos;
      if (is_illegal_char(c)) begin
         c = fns_pkg::CH_UNDERSCORE;
         name_flags[0] = 1'b1;
      end
      if (p < 3'd4) head[p[1:0]] = c;
      three_dev = head_word() == fns_pkg::DEV_CON || head_word() == fns_pkg::DEV_PRN ||
                  head_word() == fns_pkg::DEV_AUX || head_word() == fns_pkg::DEV_NUL;
      num_dev = head[3] >= fns_pkg::CH_DIGIT_LO && head[3] <= fns_pkg::CH_DIGIT_HI &&
                (head_word() == fns_pkg::DEV_COM || head_word() == fns_pkg::DEV_LPT);

      if (p == 3'd0 && c == fns_pkg::CH_SPACE) name_flags[1] = 1'b1;
      if (p == 3'd3 && c == fns_pkg::CH_DOT && three_dev) name_flags[1] = 1'b1;
      if (p == 3'd4 && c == fns_pkg::CH_DOT && num_dev) name_flags[1] = 1'b1;
      if (last) begin
         if (p == 3'd2 && three_dev) name_flags[1] = 1'b1;
         if (p == 3'd3 && num_dev) name_flags[1] = 1'b1;
         if (p == 3'd0 && c == fns_pkg::CH_DOT) begin
            c = fns_pkg::CH_UNDERSCORE;
            name_flags[0] = 1'b1;
         end
         if (p == 3'd1 && head[0] == fns_pkg::CH_DOT && c == fns_pkg::CH_DOT) begin
            head[0] = fns_pkg::CH_UNDERSCORE;
            c = fns_pkg::CH_UNDERSCORE;
            name_flags[0] = 1'b1;
         end
         if (p >= 3'd1 && (c == fns_pkg::CH_DOT || c == fns_pkg::CH_SPACE)) begin
            name_flags[1] = 1'b1;
         end
      end

      // first two bytes are held until the third byte or the end of the name
      case (p)
         3'd0: begin
            if (last) expect_beat(c, 1'b1);
         end
         3'd1: begin
            if (last) begin
               expect_beat(head[0], 1'b0);
               expect_beat(c, 1'b1);
            end
         end
         3'd2: begin
            expect_beat(head[0], 1'b0);
            expect_beat(head[1], 1'b0);
            expect_beat(c, last);
         end
         default: expect_beat(c, last);
      endcase

      if (last) begin
         name_pos   = 3'd0;
         name_flags = 2'd0;
      end else if (p < fns_pkg::POS_SAT) begin
         name_pos = p + 3'd1;
      end else begin
         name_pos = fns_pkg::POS_SAT;
      end
   endtask

   task automatic note_mismatch(input string msg);
      if (fail_count < 10) $display("%0t: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      clean_beat_type want;
      if (reset) begin
         expected_beats.delete();
         name_pos   = 3'd0;
         name_flags = 2'd0;
         for (int i = 0; i < 4; i++) head[i] = 8'd0;
      end else begin
         if (req_valid && !req_stall) predict_clean_bytes(req_in_byte, req_in_last);
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               note_mismatch($sformatf("unexpected beat byte=%02h last=%0b status=%0d",
                                       rsp_out_byte, rsp_out_last, rsp_status));
            end else begin
               want = expected_beats.pop_front();
               if (rsp_out_byte !== want.ch || rsp_out_last !== want.last ||
                   rsp_status !== want.status) begin
                  note_mismatch($sformatf(
                     "expected byte=%02h last=%0b status=%0d, got byte=%02h last=%0b status=%0d",
                     want.ch, want.last, want.status, rsp_out_byte, rsp_out_last, rsp_status));
               end
            end
         end
      end
      pending <= expected_beats.size();
   end

endmodule

### tb/tb_file_name_sanitizer.sv
`timescale 1ns / 1ps
// Testbench top for file_name_sanitizer: directed and random names, bursty sender,
// patterned rsp stall. Depends on fns_pkg, the RTL and sanitized_name_checker.
module tb_file_name_sanitizer;

   localparam int IDLE_LIMIT = 2000;
   localparam int NAME_BYTES = 400;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_in_byte = 8'd0;
   logic       req_in_last = 1'b0;
   logic       rsp_stall   = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic [1:0] rsp_status;

   int         mismatches;
   int         pending;
   int         idle_cycles = 0;
   int         burst_left  = 0;
   int         bytes_sent  = 0;
   int         stall_mode  = 0;
   int         stall_phase = 0;
   logic [7:0] name_bytes[$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   file_name_sanitizer dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_status   (rsp_status)
   );

   sanitized_name_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_status   (rsp_status),
      .mismatches   (mismatches),
      .pending      (pending)
   );

   // receiver: free, light, heavy or periodic stall, the mode picked anew at random when stall_phase reaches zero
   always @(posedge clock) begin
      if (stall_phase == 0) begin
         stall_mode  <= $urandom_range(0, 3);
         stall_phase <= $urandom_range(16, 160);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_phase % 7) < 3;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_file_name_sanitizer: errors");
         $finish;
      end
   end

   task automatic send_name();
      int gap;
      for (int i = 0; i < name_bytes.size(); i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         req_valid   <= 1'b1;
         req_in_byte <= name_bytes[i];
         req_in_last <= (i == name_bytes.size() - 1);
         @(posedge clock);
         while (req_stall) @(posedge clock);
         bytes_sent++;
      end
   endtask

   task automatic send_text(input string s);
      name_bytes.delete();
      for (int i = 0; i < s.len(); i++) name_bytes.push_back(s[i]);
      send_name();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_name_char();
      string odd_set;
      odd_set = "\\/:*?\"<>|";
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(0, 255));
         1: return odd_set[$urandom_range(0, 8)];
         2: return 8'($urandom_range(8'h20, 8'h7E));
         default: return $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) :
                                                8'($urandom_range(128, 255));
      endcase
   endfunction

   task automatic build_random_name();
      string      devs;
      string      short_set;
      int         kind;
      int         len;
      int         k;
      logic [7:0] ch;
      devs      = "CONPRNAUXNULCOMLPT";
      short_set = ". a_";
      name_bytes.delete();
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         // device-like prefix in random case, maybe a byte from '0' to ':', then end, dot, dot and tail, or tail
         k = $urandom_range(0, 5);
         for (int i = 0; i < 3; i++) begin
            ch = devs[3 * k + i];
            if ($urandom_range(0, 1)) ch = ch + 8'd32;
            name_bytes.push_back(ch);
         end
         if ($urandom_range(0, 4) < ((k >= 4) ? 4 : 1))
            name_bytes.push_back(8'($urandom_range(8'h30, 8'h3A)));
         case ($urandom_range(0, 3))
            0: ;
            1: name_bytes.push_back(".");
            2: begin
               name_bytes.push_back(".");
               len = $urandom_range(1, 6);
               repeat (len) name_bytes.push_back(rand_name_char());
            end
            default: begin
               len = $urandom_range(1, 6);
               repeat (len) name_bytes.push_back(rand_name_char());
            end
         endcase
      end else if (kind < 6) begin
         len = $urandom_range(1, 3);
         repeat (len) name_bytes.push_back(short_set[$urandom_range(0, 3)]);
      end else begin
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         repeat (len) name_bytes.push_back(rand_name_char());
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_text(".");
      send_text("..");
      send_text("CON");
      send_text("nul.a");
      send_text("Lpt9");
      name_bytes.delete();
      name_bytes.push_back(" ");
      name_bytes.push_back(8'h01);
      name_bytes.push_back(8'h1F);
      send_name();
      name_bytes.delete();
      name_bytes.push_back(8'hFF);
      name_bytes.push_back(8'h00);
      name_bytes.push_back(" ");
      send_name();
      send_text(":*?|");
      wait_drained();

      while (bytes_sent < NAME_BYTES + 25) begin
         build_random_name();
         send_name();
         if ($urandom_range(0, 24) == 0) wait_drained();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_file_name_sanitizer: clean");
      end else begin
         $display("tb_file_name_sanitizer: errors");
      end
      $finish;
   end

endmodule

### files.f
src/fns_pkg.sv
src/fns_front.sv
src/fns_fifo.sv
src/fns_back.sv
src/file_name_sanitizer.sv
tb/sanitized_name_checker.sv
tb/tb_file_name_sanitizer.sv
